[hw/rtl/cld_pkg.sv]
// ----------------------------------------------------------------------------
// Delta patch decoder package
// Result kind codes and fixed constants shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package cld_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_LITERAL = 2'd0;
    localparam t_kind KIND_COPY    = 2'd1;
    localparam t_kind KIND_END     = 2'd2;

    // A copy moves the 15-bit header length plus this bias.
    localparam logic [15:0] COPY_BIAS = 16'd6;

endpackage

[hw/rtl/copy_literal_delta_decoder_top.sv]
// ----------------------------------------------------------------------------
// Copy/literal delta patch decoder
// Parses delta command bytes into literal bytes and copy commands.
// ----------------------------------------------------------------------------
// The decoder accepts one command byte per clock cycle while o_in_ready is
// high. The parse state (phase, header, offset, literal count, consumed and
// output positions) is updated at the edge that accepts the byte. Any result
// that byte produces appears in the output register at that same edge, so a
// result reaches the output port in the cycle after its byte. The output
// register is the only buffering. A byte can be taken while a result is on
// the output port, provided the sink takes that result in the same cycle.
// After the command that reaches the configured byte count, the result
// carries o_last and o_total_size. From then on, bytes are accepted and
// dropped until reset. Write i_cfg_wr_data only while the decoder is idle.
module copy_literal_delta_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_delta_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_copy_offset,
    output logic [15:0] o_copy_length,
    output logic [31:0] o_dest_position,
    output logic        o_last,
    output logic [31:0] o_total_size
);

    localparam logic [2:0] PH_HLO  = 3'd0;
    localparam logic [2:0] PH_HHI  = 3'd1;
    localparam logic [2:0] PH_OFF0 = 3'd2;
    localparam logic [2:0] PH_OFF1 = 3'd3;
    localparam logic [2:0] PH_OFF2 = 3'd4;
    localparam logic [2:0] PH_OFF3 = 3'd5;
    localparam logic [2:0] PH_LIT  = 3'd6;

    logic [31:0] r_cmd_bytes;
    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_header, n_header;
    logic [31:0] r_offset, n_offset;
    logic [14:0] r_lit_left, n_lit_left;
    logic [31:0] r_consumed, n_consumed;
    logic [31:0] r_out_pos, n_out_pos;
    logic        r_finished, n_finished;

    logic        r_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_data, n_data;
    logic [31:0] r_copy_off, n_copy_off;
    logic [15:0] r_copy_len, n_copy_len;
    logic [31:0] r_dest, n_dest;
    logic        r_last, n_last;
    logic [31:0] r_total, n_total;
    logic        n_emit;

    logic        accept;
    logic [32:0] consumed_sum;
    logic [32:0] pos_sum;
    logic [15:0] copy_len;
    logic [15:0] pos_inc;
    logic [14:0] lit_dec;
    logic        end_reached;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign consumed_sum = {1'b0, r_consumed} + 33'd1;
    assign copy_len     = {1'b0, r_header[14:0]} + cld_pkg::COPY_BIAS;
    assign pos_inc      = (r_phase == PH_LIT) ? 16'd1 : copy_len;
    assign pos_sum      = {1'b0, r_out_pos} + {17'd0, pos_inc};
    assign lit_dec      = r_lit_left - 15'd1;

    always_comb begin
        n_phase    = r_phase;
        n_header   = r_header;
        n_offset   = r_offset;
        n_lit_left = r_lit_left;
        n_consumed = consumed_sum[32] ? 32'hffff_ffff : consumed_sum[31:0];
        n_out_pos  = r_out_pos;
        n_finished = r_finished;
        n_emit     = 1'b0;
        n_kind     = cld_pkg::KIND_LITERAL;
        n_data     = 8'd0;
        n_copy_off = 32'd0;
        n_copy_len = 16'd0;
        n_dest     = r_out_pos;
        n_last     = 1'b0;
        n_total    = 32'd0;
        // The end test uses the consumed count including this byte.
        end_reached = (n_consumed >= r_cmd_bytes);

        unique case (r_phase)
            PH_HHI: begin
                n_header = {i_delta_byte, r_header[7:0]};
                if (i_delta_byte[7]) begin
                    n_offset = 32'd0;
                    n_phase  = PH_OFF0;
                end else begin
                    n_lit_left = {i_delta_byte[6:0], r_header[7:0]};
                    if (n_lit_left != 15'd0) begin
                        n_phase = PH_LIT;
                    end else begin
                        // Empty literal: only visible when it ends the patch.
                        n_phase = PH_HLO;
                        if (end_reached) begin
                            n_finished = 1'b1;
                            n_emit     = 1'b1;
                            n_kind     = cld_pkg::KIND_END;
                            n_last     = 1'b1;
                            n_total    = r_out_pos;
                        end
                    end
                end
            end
            PH_OFF0: begin
                n_offset[7:0] = i_delta_byte;
                n_phase       = PH_OFF1;
            end
            PH_OFF1: begin
                n_offset[15:8] = i_delta_byte;
                n_phase        = PH_OFF2;
            end
            PH_OFF2: begin
                n_offset[23:16] = i_delta_byte;
                n_phase         = PH_OFF3;
            end
            PH_OFF3: begin
                n_offset[31:24] = i_delta_byte;
                n_out_pos  = pos_sum[32] ? 32'hffff_ffff : pos_sum[31:0];
                n_phase    = PH_HLO;
                n_emit     = 1'b1;
                n_kind     = cld_pkg::KIND_COPY;
                n_copy_off = n_offset;
                n_copy_len = copy_len;
                if (end_reached) begin
                    n_finished = 1'b1;
                    n_last     = 1'b1;
                    n_total    = n_out_pos;
                end
            end
            PH_LIT: begin
                n_out_pos  = pos_sum[32] ? 32'hffff_ffff : pos_sum[31:0];
                n_lit_left = lit_dec;
                n_emit     = 1'b1;
                n_kind     = cld_pkg::KIND_LITERAL;
                n_data     = i_delta_byte;
                if (lit_dec == 15'd0) begin
                    n_phase = PH_HLO;
                    if (end_reached) begin
                        n_finished = 1'b1;
                        n_last     = 1'b1;
                        n_total    = n_out_pos;
                    end
                end
            end
            default: begin
                // Header low byte; the unused phase code lands here too.
                n_header = {8'd0, i_delta_byte};
                n_phase  = PH_HHI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_bytes <= 32'd0;
            r_phase     <= PH_HLO;
            r_header    <= 16'd0;
            r_offset    <= 32'd0;
            r_lit_left  <= 15'd0;
            r_consumed  <= 32'd0;
            r_out_pos   <= 32'd0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cmd_bytes <= i_cfg_wr_data;
            end
            if (accept && !r_finished) begin
                r_phase     <= n_phase;
                r_header    <= n_header;
                r_offset    <= n_offset;
                r_lit_left  <= n_lit_left;
                r_consumed  <= n_consumed;
                r_out_pos   <= n_out_pos;
                r_finished  <= n_finished;
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_finished && n_emit) begin
            r_kind     <= n_kind;
            r_data     <= n_data;
            r_copy_off <= n_copy_off;
            r_copy_len <= n_copy_len;
            r_dest     <= n_dest;
            r_last     <= n_last;
            r_total    <= n_total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data;
    assign o_copy_offset   = r_copy_off;
    assign o_copy_length   = r_copy_len;
    assign o_dest_position = r_dest;
    assign o_last          = r_last;
    assign o_total_size    = r_total;

endmodule

[hw/rtl/cld_checker.sv]
// ----------------------------------------------------------------------------
// Delta patch decoder checker
// Port-level assertions on the decoder's result channel.
// ----------------------------------------------------------------------------
module cld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [15:0] o_copy_length,
    input logic        o_last,
    input logic [31:0] o_total_size
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_last) && $stable(o_total_size))
        else $error("result beat changed while stalled");

    // An end-only result only exists to finish the patch.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == cld_pkg::KIND_END |-> o_last)
        else $error("end marker without last");

    a_total_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_total_size == 32'd0)
        else $error("total size set on a beat that is not last");

    a_copy_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == cld_pkg::KIND_COPY |-> o_copy_length >= cld_pkg::COPY_BIAS)
        else $error("copy length below bias");

    // Nothing follows the last beat until reset.
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last |=> !o_out_valid)
        else $error("result after last beat");

endmodule

bind copy_literal_delta_decoder_top cld_checker u_cld_checker (.*);
